### hdl/dws_pkg.sv
// ----------------------------------------------------------------------------
// dws_pkg
// Shared types and codes for the double-ended queue with search.
// ----------------------------------------------------------------------------
package dws_pkg;

    // Request codes carried in the action field.
    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_SEARCH     = 3'd4
    } action_t;

    // Completion codes carried in the status field.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } state_t;

    // Per-cycle command broadcast to every storage cell.
    typedef struct packed {
        logic shift_right;   // push at the front: every entry moves one place back
        logic shift_left;    // pop at the front: every entry moves one place forward
        logic push_back;     // write the new value into the first free cell
    } cell_cmd_t;

endpackage

### hdl/dws_if.sv
// ----------------------------------------------------------------------------
// dws_if
// Valid/ready channels for requests into and results out of the queue.
// ----------------------------------------------------------------------------

// Request channel: one queue operation and its operand.
interface dws_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic signed [31:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

// Result channel: search outcome and completion status.
interface dws_rsp_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [1:0] status;

    modport source (output valid, output found, output status, input ready);
    modport sink   (input valid, input found, input status, output ready);
endinterface

### hdl/dws_cell.sv
// ----------------------------------------------------------------------------
// dws_cell
// One storage cell of the queue: holds the entry at a fixed position from
// the front and passes a search key along to the next cell.
// ----------------------------------------------------------------------------
module dws_cell
    import dws_pkg::*;
#(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_cmd_t          cmd,
    input  logic [CNT_W-1:0]   count,
    input  logic signed [31:0] value,
    input  logic signed [31:0] left_data,
    input  logic signed [31:0] right_data,
    output logic signed [31:0] data,
    input  logic signed [31:0] key_in,
    input  logic               tok_in,
    input  logic               hit_in,
    output logic signed [31:0] key_out,
    output logic               tok_out,
    output logic               hit_out
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic signed [31:0] key_reg;
    logic               tok_reg;
    logic               tok_next;
    logic               hit_reg;
    logic               hit_next;
    logic               occupied;

    // The cell holds a live entry when its position lies below the count.
    assign occupied = (IDX_C < count);

    // Entry update: shift with the neighbours or take a value at the back.
    always_comb
    begin
        data_next = data_reg;
        if (cmd.shift_right)
        begin
            data_next = left_data;
        end
        else if (cmd.shift_left)
        begin
            data_next = right_data;
        end
        else if (cmd.push_back && (count == IDX_C))
        begin
            data_next = value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        key_reg  <= key_in;
    end

    // The search token moves one cell a cycle and gathers a match on the way.
    always_comb
    begin
        tok_next = tok_in;
        hit_next = hit_in | (tok_in & occupied & (data_reg == key_in));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            hit_reg <= hit_next;
        end
    end

    assign data    = data_reg;
    assign key_out = key_reg;
    assign tok_out = tok_reg;
    assign hit_out = hit_reg;

endmodule

### hdl/deque_with_search.sv
// ----------------------------------------------------------------------------
// deque_with_search
// Bounded double-ended queue of signed 32-bit values with a search request.
// ----------------------------------------------------------------------------
// The queue is a row of DEPTH cells; cell k always holds the k-th entry from
// the front, so a push or pop at the front moves every entry one cell, while
// a push or pop at the back only touches the count. Each request gives
// exactly one result. Pushes and pops complete when taken, and a new request
// can be taken in every cycle while the result register drains. A search
// sends the key down the row of cells, one cell per cycle; its result is
// registered once the token leaves the last cell and the result register is
// free, and no further request is taken until then. A push into a full
// queue is dropped with status full; a pop on an empty queue reports empty.
// ----------------------------------------------------------------------------
module deque_with_search
    import dws_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    dws_req_if.sink   req,
    dws_rsp_if.source rsp
);

    localparam int               CNT_W   = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic               found_reg;
    logic               found_next;
    status_t            status_reg;
    status_t            status_next;
    logic               hold_reg;
    logic               hold_next;

    cell_cmd_t          cmd;
    logic               accept;
    logic               rsp_free;
    logic               full;
    logic               empty;
    logic               search_start;

    logic signed [31:0] data_w [DEPTH];
    logic signed [31:0] key_w  [DEPTH];
    logic [DEPTH-1:0]   tok_w;
    logic [DEPTH-1:0]   hit_w;

    assign full     = (count_reg == DEPTH_C);
    assign empty    = (count_reg == '0);
    assign rsp_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && rsp_free;
    assign accept   = req.valid && req.ready;

    // Row of storage cells.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [31:0] left_d;
        logic signed [31:0] right_d;
        logic signed [31:0] key_d;
        logic               tok_d;
        logic               hit_d;

        if (i == 0)
        begin : g_head
            assign left_d = req.value;
            assign key_d  = req.value;
            assign tok_d  = search_start;
            assign hit_d  = 1'b0;
        end
        else
        begin : g_body
            assign left_d = data_w[i-1];
            assign key_d  = key_w[i-1];
            assign tok_d  = tok_w[i-1];
            assign hit_d  = hit_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_d = data_w[i];
        end
        else
        begin : g_inner
            assign right_d = data_w[i+1];
        end

        dws_cell #(
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .count      (count_reg),
            .value      (req.value),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (data_w[i]),
            .key_in     (key_d),
            .tok_in     (tok_d),
            .hit_in     (hit_d),
            .key_out    (key_w[i]),
            .tok_out    (tok_w[i]),
            .hit_out    (hit_w[i])
        );
    end

    // Request decode, count update, result register and controller.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        found_next     = found_reg;
        status_next    = status_reg;
        hold_next      = hold_reg;
        cmd            = '0;
        search_start   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next = 1'b1;
                    found_next     = 1'b0;
                    status_next    = ST_DONE;
                    unique case (req.action)
                        ACT_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.shift_right = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.push_back = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.shift_left = 1'b1;
                                count_next     = count_reg - CNT_W'(1);
                            end
                        end
                        ACT_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        ACT_SEARCH:
                        begin
                            rsp_valid_next = rsp_valid_reg && !rsp.ready;
                            search_start   = 1'b1;
                            state_next     = S_SEARCH;
                        end
                        default:
                        begin
                            // Unused codes leave the queue alone and report done.
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (tok_w[DEPTH-1])
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_next = 1'b1;
                        found_next     = hit_w[DEPTH-1];
                        status_next    = ST_DONE;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        hold_next  = hit_w[DEPTH-1];
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    found_next     = hold_reg;
                    status_next    = ST_DONE;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        status_reg <= status_next;
        hold_reg   <= hold_next;
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.found  = found_reg;
    assign rsp.status = status_reg;

`ifndef NO_ASSERTIONS
    // The count never exceeds the number of cells.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("queue count above depth");

    // At most one search key travels down the row at a time.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_w))
        else $error("more than one search token in the cells");

    // A token only reaches the last cell while a search is under way.
    a_token_state: assert property (@(posedge clk) disable iff (!rst_n)
        tok_w[DEPTH-1] |-> (state_reg == S_SEARCH))
        else $error("search token outside a search");

    // The queue count does not change while a search runs.
    a_search_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |=> $stable(count_reg))
        else $error("count changed during a search");

    // A pop on an empty queue reports empty in the next cycle.
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && empty && ((req.action == ACT_POP_FRONT) || (req.action == ACT_POP_BACK)))
        |=> (rsp_valid_reg && (status_reg == ST_EMPTY)))
        else $error("pop on empty queue not reported");
`endif

endmodule

### tb/sv/deque_with_search_tb.sv
// ----------------------------------------------------------------------------
// deque_with_search_tb
// Self-checking bench for the bounded double-ended queue with search.
// ----------------------------------------------------------------------------
// Requests are driven on the request channel in bursts with random gaps. The
// result channel is stalled on a changing pattern, with one long hold-off
// that backs the queue up into its request port. Every accepted request
// updates a behavioural copy of the queue, which predicts found and status.
// Each accepted result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module deque_with_search_tb;
    import dws_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          QDEPTH           = 16;
    localparam int          RANDOM_REQUESTS  = 1800;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          STALL_LIMIT      = 4000;
    localparam logic [2:0]  ACT_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]  ACT_UNUSED_LAST  = 3'd7;
    localparam logic [31:0] INT32_MIN        = 32'h8000_0000;
    localparam logic [31:0] INT32_MAX        = 32'h7FFF_FFFF;

    // Bias of the request mix over one stretch of random traffic.
    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    // Shape of the result-side ready pattern over one stretch.
    typedef enum {RX_FREE, RX_HALF, RX_SLOW, RX_MOSTLY} rx_mode_t;

    typedef struct packed {
        logic       found;
        logic [1:0] status;
    } outcome_t;

    // Behavioural copy of the queue and the results it still owes.
    class deque_scoreboard;
        int          depth;
        logic [31:0] contents[$];
        outcome_t    awaited[$];
        int unsigned errors;
        int unsigned checked;

        function new(int depth_i);
            depth   = depth_i;
            errors  = 0;
            checked = 0;
        endfunction

        task report(string what);
            $display("ERROR at %0t ns: %s", $time, what);
            errors++;
        endtask

        // Apply one accepted request and record the result it must give.
        task note_request(logic [2:0] act, logic [31:0] val);
            outcome_t o;
            o.found  = 1'b0;
            o.status = ST_DONE;
            case (act)
                ACT_PUSH_FRONT:
                    if (contents.size() >= depth) o.status = ST_FULL;
                    else contents.push_front(val);
                ACT_PUSH_BACK:
                    if (contents.size() >= depth) o.status = ST_FULL;
                    else contents.push_back(val);
                ACT_POP_FRONT:
                    if (contents.size() == 0) o.status = ST_EMPTY;
                    else void'(contents.pop_front());
                ACT_POP_BACK:
                    if (contents.size() == 0) o.status = ST_EMPTY;
                    else void'(contents.pop_back());
                ACT_SEARCH:
                    foreach (contents[i])
                        if (contents[i] == val) o.found = 1'b1;
                default:
                    ;
            endcase
            awaited.push_back(o);
        endtask

        // Compare one accepted result with the oldest prediction.
        task check_result(logic found, logic [1:0] status);
            outcome_t o;
            checked++;
            if (awaited.size() == 0)
            begin
                report("result arrived with no request outstanding");
                return;
            end
            o = awaited.pop_front();
            if (found !== o.found)
                report($sformatf("result %0d: found %b, predicted %b",
                                 checked, found, o.found));
            if (status !== o.status)
                report($sformatf("result %0d: status %0d, predicted %0d",
                                 checked, status, o.status));
        endtask

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dws_req_if req ();
    dws_rsp_if rsp ();

    deque_with_search #(.DEPTH(QDEPTH)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    deque_scoreboard sb;
    int              burst_left;
    int              stall_cycles;
    bit              long_hold_done;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Reset is held at the start of the run only.
    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Observe both channels; a long stretch with no transfer ends the run.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (req.valid === 1'b1 && req.ready === 1'b1)
                sb.note_request(req.action, req.value);
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                sb.check_result(rsp.found, rsp.status);
            if ((req.valid === 1'b1 && req.ready === 1'b1) ||
                (rsp.valid === 1'b1 && rsp.ready === 1'b1))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("FAIL deque_with_search");
                    $finish;
                end
            end
        end
    end

    // Result side: ready follows a changing pattern, with one long hold-off
    // once traffic is under way so that the queue backs up.
    initial
    begin : result_sink
        rx_mode_t    rx_mode;
        int unsigned span;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            span    = $urandom_range(16, 160);
            if (!long_hold_done && sb.checked >= 200)
            begin
                long_hold_done = 1'b1;
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            repeat (span)
            begin
                case (rx_mode)
                    RX_FREE:   rsp.ready <= 1'b1;
                    RX_HALF:   rsp.ready <= ($urandom_range(0, 1) == 0);
                    RX_SLOW:   rsp.ready <= ($urandom_range(0, 3) == 0);
                    default:   rsp.ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Offer one request and return at the edge where it is taken. Between
    // bursts the request line may drop for a random gap.
    task automatic send_request(input logic [2:0] act, input logic [31:0] val);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                                     : $urandom_range(1, 40);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.valid  <= 1'b1;
        req.action <= act;
        req.value  <= val;
        @(posedge clk);
        while (req.ready !== 1'b1) @(posedge clk);
    endtask

    // Operand mix: small values so that searches hit, extremes, and full
    // random words so that every bit toggles.
    function automatic logic [31:0] pick_value();
        int unsigned pick;
        int          small_val;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            small_val = int'($urandom_range(0, 15)) - 8;
            return small_val;
        end
        else if (pick < 50)
        begin
            case ($urandom_range(0, 3))
                0:       return INT32_MIN;
                1:       return INT32_MAX;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Main stimulus: directed cases, random traffic, drain and verdict.
    initial
    begin : stimulus
        mix_t        mix;
        int unsigned stretch;
        int unsigned roll;
        int          sent;
        logic [2:0]  act;
        sb             = new(QDEPTH);
        burst_left     = 0;
        stall_cycles   = 0;
        long_hold_done = 1'b0;
        req.valid  <= 1'b0;
        req.action <= ACT_SEARCH;
        req.value  <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Empty queue: both pops report empty, a search finds nothing, and
        // the unused request codes leave everything unchanged.
        send_request(ACT_POP_FRONT, $urandom);
        send_request(ACT_POP_BACK, $urandom);
        send_request(ACT_SEARCH, 32'h0000_0000);
        for (int c = ACT_UNUSED_FIRST; c <= ACT_UNUSED_LAST; c++)
            send_request(3'(c), $urandom);

        // Extremes at both ends, then hits on both extremes and a miss.
        send_request(ACT_PUSH_FRONT, INT32_MIN);
        send_request(ACT_PUSH_BACK, INT32_MAX);
        send_request(ACT_PUSH_FRONT, 32'h0000_0000);
        send_request(ACT_PUSH_BACK, 32'hFFFF_FFFF);
        send_request(ACT_SEARCH, INT32_MIN);
        send_request(ACT_SEARCH, INT32_MAX);
        send_request(ACT_SEARCH, 32'h0000_0001);

        // Fill to capacity with alternating bit patterns, then push at
        // both ends into the full queue and search for the deepest entry.
        for (int i = 0; i < QDEPTH - 4; i++)
            send_request(ACT_PUSH_BACK, (i % 2 == 1) ? (32'hAAAA_AAA0 | i)
                                                     : (32'h5555_5550 | i));
        send_request(ACT_PUSH_FRONT, 32'h1234_5678);
        send_request(ACT_PUSH_BACK, 32'h8765_4321);
        send_request(ACT_SEARCH, 32'hAAAA_AAAB);

        // Random traffic in stretches that lean towards filling, draining
        // or neither, so the queue swings between empty and full.
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            mix     = mix_t'($urandom_range(0, 2));
            stretch = $urandom_range(20, 120);
            repeat (stretch)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    act = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
                else if (roll < 28)
                    act = ACT_SEARCH;
                else
                begin
                    roll = $urandom_range(0, 99);
                    if ((mix == MIX_FILL && roll < 75) ||
                        (mix == MIX_DRAIN && roll < 25) ||
                        (mix == MIX_EVEN && roll < 50))
                        act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
                    else
                        act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
                end
                send_request(act, pick_value());
                if (act < ACT_UNUSED_FIRST)
                    sent++;
            end
        end

        // Let every outstanding result drain, then allow a search's latency
        // for anything unexpected to appear.
        req.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (QDEPTH + 8) @(posedge clk);

        if (sb.errors == 0)
            $display("PASS deque_with_search");
        else
            $display("FAIL deque_with_search");
        $finish;
    end

endmodule

### files.f
hdl/dws_pkg.sv
hdl/dws_if.sv
hdl/dws_cell.sv
hdl/deque_with_search.sv
tb/sv/deque_with_search_tb.sv
